// ===== rtl/rvstep_pkg.sv =====
// Package: shared types, codes and constants of the RV32E-subset step unit.
`timescale 1ns / 1ps
package rvstep_pkg;

   // default memory size in bytes
   localparam int unsigned MEM_BYTES_DEF = 65536;

   // item commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   // result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_ILLEGAL  = 3'd1;
   localparam logic [2:0] ST_MEMFAULT = 3'd2;
   localparam logic [2:0] ST_GOOD     = 3'd3;
   localparam logic [2:0] ST_BAD      = 3'd4;

   // opcodes
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_SYSTEM = 7'h73;

   // funct3 codes
   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_W   = 3'd2;
   localparam logic [2:0] F3_B   = 3'd0;
   localparam logic [2:0] F3_BU  = 3'd4;

   localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
   localparam logic [31:0] LUI_MASK    = 32'hFFFF_F000;
   localparam logic [11:0] IMM_MASK    = 12'hFFF;
   localparam logic [3:0]  REG_A0      = 4'd10;

   // frame buffer window: 0x20000000, 256K bytes
   localparam logic [31:0] FB_BASE = 32'h2000_0000;
   localparam logic [13:0] FB_TAG  = FB_BASE[31:18];

   typedef struct packed {
      logic        cmd;
      logic [15:0] load_addr;
      logic [7:0]  load_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] next_pc;
      logic        pixel_write;
      logic [15:0] pixel_num;
      logic [31:0] pixel_data;
      logic [3:0]  pixel_byte_enable;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic clear_en;
      logic load_en;
      logic fetch_en;
      logic decode_en;
      logic exec_en;
      logic mem_en;
      logic done_en;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic is_load;
      logic pc_ok;
      logic need_mem;
      logic out_busy;
   } dp_stat_type;

   // controller states
   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_LOAD   = 8'b0000_0100,
      S_FETCH  = 8'b0000_1000,
      S_DECODE = 8'b0001_0000,
      S_EXEC   = 8'b0010_0000,
      S_MEM    = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

endpackage

// ===== rtl/rvstep_ctrl.sv =====
// Controller: state machine sequencing clear, load and instruction steps.
`timescale 1ns / 1ps
module rvstep_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rvstep_pkg::dp_stat_type   stat,
   output rvstep_pkg::ctrl_cmd_type  cmd,
   output rvstep_pkg::state_type     state
);
   import rvstep_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state     = state_ff;
   assign req_stall = (state_ff != S_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_FETCH;
            end
         end
         S_FETCH: begin
            if (stat.is_load) begin
               state_in = S_LOAD;
            end else begin
               cmd.fetch_en = 1'b1;
               state_in     = stat.pc_ok ? S_DECODE : S_DONE;
            end
         end
         S_LOAD: begin
            cmd.load_en = 1'b1;
            state_in    = S_DONE;
         end
         S_DECODE: begin
            cmd.decode_en = 1'b1;
            state_in      = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec_en = 1'b1;
            state_in    = stat.need_mem ? S_MEM : S_DONE;
         end
         S_MEM: begin
            cmd.mem_en = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.done_en = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/rvstep_dpath.sv =====
// Datapath: PC, register file, byte-lane memory banks, execute logic, result register.
`timescale 1ns / 1ps
module rvstep_dpath #(
   parameter int unsigned MEM_BYTES = rvstep_pkg::MEM_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rvstep_pkg::req_word_type  req_word,
   input  rvstep_pkg::ctrl_cmd_type  cmd,
   output rvstep_pkg::dp_stat_type   stat,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output rvstep_pkg::rsp_word_type  rsp_word
);
   import rvstep_pkg::*;

   localparam int unsigned WORDS = (MEM_BYTES + 3) / 4;
   localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [32:0] MEM_END = 33'(MEM_BYTES);

   // registers
   req_word_type req_ff;
   logic [31:0]  pc_ff;
   logic [31:0]  inst_ff;
   logic [31:0]  addr_ff;
   logic [31:0]  a_data_ff, b_data_ff;
   logic [WAW-1:0] clr_idx_ff;
   rsp_word_type res_ff, res_in;
   rsp_word_type rsp_word_ff;
   logic         rsp_valid_ff;

   // register file with valid bits
   logic [31:0] rf_mem [16];
   logic [15:0] rf_vld_ff;
   logic        rf_we;
   logic [3:0]  rf_waddr;
   logic [31:0] rf_wdata;
   logic [3:0]  rf_raddr_a, rf_raddr_b;

   // memory banks
   logic [7:0]     mem_bank [4][WORDS];
   logic [3:0]     mem_we;
   logic [WAW-1:0] mem_waddr, mem_raddr;
   logic [7:0]     mem_wdata [4];
   logic [7:0]     mem_rdata_ff [4];
   logic [31:0]    mem_rword;

   // decode fields
   logic [6:0]  op;
   logic [4:0]  rd, rs1, rs2;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i, imm_s, pc_plus4, ea, npc;
   logic [2:0]  st;
   logic        st_load, st_store_mem, st_byte, wb_now;
   logic        pix_w;
   logic [31:0] pix_data;
   logic [3:0]  pix_be;
   logic        ea_word_ok, ea_byte_ok, ea_in_fb;
   logic [32:0] ld_addr33;

   assign mem_rword = {mem_rdata_ff[3], mem_rdata_ff[2], mem_rdata_ff[1], mem_rdata_ff[0]};

   // register read addresses: during decode from memory, later from the latch; other fields from the latch
   logic [31:0] dec_word;
   assign dec_word = cmd.decode_en ? mem_rword : inst_ff;
   assign op  = inst_ff[6:0];
   assign rd  = inst_ff[11:7];
   assign f3  = inst_ff[14:12];
   assign rs1 = inst_ff[19:15];
   assign rs2 = inst_ff[24:20];
   assign f7  = inst_ff[31:25];
   assign imm_i = {{20{inst_ff[31]}}, inst_ff[31:20] & IMM_MASK};
   assign imm_s = {{20{inst_ff[31]}}, inst_ff[31:25], inst_ff[11:7]};
   assign pc_plus4 = pc_ff + 32'd4;

   // bounds checks
   assign ea_word_ok = (ea[1:0] == 2'b00) && ({1'b0, ea} + 33'd4 <= MEM_END);
   assign ea_byte_ok = ({1'b0, ea} < MEM_END);
   assign ea_in_fb   = (ea[31:18] == FB_TAG);
   assign stat.pc_ok = (pc_ff[1:0] == 2'b00) && ({1'b0, pc_ff} + 33'd4 <= MEM_END);
   assign ld_addr33  = {17'd0, req_ff.load_addr};

   // execute: outcome of one instruction
   always_comb begin
      st           = ST_ILLEGAL;
      npc          = pc_plus4;
      ea           = a_data_ff + ((op == OP_STORE) ? imm_s : imm_i);
      wb_now       = 1'b0;
      rf_wdata     = 32'd0;
      st_load      = 1'b0;
      st_store_mem = 1'b0;
      st_byte      = 1'b0;
      pix_w        = 1'b0;
      pix_data     = 32'd0;
      pix_be       = 4'd0;
      if (op == OP_IMM && f3 == F3_ADD) begin
         if (!rd[4] && !rs1[4]) begin
            wb_now = 1'b1; rf_wdata = a_data_ff + imm_i; st = ST_OK;
         end
      end else if (op == OP_JALR && f3 == F3_ADD) begin
         if (!rd[4] && !rs1[4]) begin
            wb_now = 1'b1; rf_wdata = pc_plus4;
            npc = (a_data_ff + imm_i) & ~32'd1; st = ST_OK;
         end
      end else if (op == OP_REG && f3 == F3_ADD && f7 == 7'd0) begin
         if (!rd[4] && !rs1[4] && !rs2[4]) begin
            wb_now = 1'b1; rf_wdata = a_data_ff + b_data_ff; st = ST_OK;
         end
      end else if (op == OP_LUI) begin
         if (!rd[4]) begin
            wb_now = 1'b1; rf_wdata = inst_ff & LUI_MASK; st = ST_OK;
         end
      end else if (op == OP_LOAD && (f3 == F3_W || f3 == F3_BU)) begin
         if (!rd[4] && !rs1[4]) begin
            if (f3 == F3_W ? ea_word_ok : ea_byte_ok) begin
               st_load = 1'b1; st = ST_OK;
            end else begin
               st = ST_MEMFAULT;
            end
         end
      end else if (op == OP_STORE && (f3 == F3_W || f3 == F3_B)) begin
         if (!rs1[4] && !rs2[4]) begin
            st_byte = (f3 == F3_B);
            if (ea_in_fb) begin
               st = ST_OK;
               if (f3 == F3_B) begin
                  pix_w    = 1'b1;
                  pix_data = {24'd0, b_data_ff[7:0]} << {ea[1:0], 3'b000};
                  pix_be   = 4'd1 << ea[1:0];
               end else if (ea[1:0] == 2'b00) begin
                  pix_w = 1'b1; pix_data = b_data_ff; pix_be = 4'hF;
               end
            end else if (f3 == F3_W ? ea_word_ok : ea_byte_ok) begin
               st_store_mem = 1'b1; st = ST_OK;
            end else begin
               st = ST_MEMFAULT;
            end
         end
      end else if (inst_ff == EBREAK_WORD) begin
         st = (b_data_ff == 32'd0) ? ST_GOOD : ST_BAD;
      end
   end

   assign stat.need_mem   = st_load;
   assign stat.is_load    = (req_ff.cmd == CMD_LOAD);
   assign stat.clear_last = (32'(clr_idx_ff) == WORDS - 1);
   assign stat.out_busy   = rsp_valid_ff && rsp_stall;

   // result word of the current item
   always_comb begin
      res_in = res_ff;
      if (cmd.load_en) begin
         res_in = '0;
         res_in.status  = ST_OK;
         res_in.next_pc = pc_ff;
      end else if (cmd.fetch_en && !stat.pc_ok) begin
         res_in = '0;
         res_in.status  = ST_MEMFAULT;
         res_in.next_pc = pc_ff;
      end else if (cmd.exec_en) begin
         res_in.status            = st;
         res_in.next_pc           = (st == ST_OK) ? npc : pc_ff;
         res_in.pixel_write       = pix_w;
         res_in.pixel_num         = pix_w ? ea[17:2] : 16'd0;
         res_in.pixel_data        = pix_data;
         res_in.pixel_byte_enable = pix_be;
      end
   end

   // item, PC, instruction and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= 32'd0;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_en) clr_idx_ff <= clr_idx_ff + 1'b1;
         if (cmd.exec_en && st == ST_OK) pc_ff <= npc;
         if (cmd.done_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req_word;
      if (cmd.decode_en) inst_ff <= mem_rword;
      if (cmd.exec_en) addr_ff <= ea;
      res_ff <= res_in;
      if (cmd.done_en) rsp_word_ff <= res_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // register file: two registered reads, one write port
   assign rf_raddr_a = dec_word[18:15];
   assign rf_raddr_b = (dec_word == EBREAK_WORD) ? REG_A0 : dec_word[23:20];

   always_comb begin
      rf_we    = 1'b0;
      rf_waddr = rd[3:0];
      if (cmd.exec_en && wb_now) rf_we = 1'b1;
      if (cmd.mem_en) rf_we = 1'b1;
      if (rd[3:0] == 4'd0) rf_we = 1'b0;
   end

   logic [31:0] rf_wval;
   assign rf_wval = cmd.mem_en ?
                    ((f3 == F3_W) ? mem_rword :
                     {24'd0, mem_rdata_ff[addr_ff[1:0]]}) : rf_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (rf_we) begin
         rf_vld_ff[rf_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) rf_mem[rf_waddr] <= rf_wval;
      if (cmd.decode_en) begin
         a_data_ff <= rf_vld_ff[rf_raddr_a] ? rf_mem[rf_raddr_a] : 32'd0;
         b_data_ff <= rf_vld_ff[rf_raddr_b] ? rf_mem[rf_raddr_b] : 32'd0;
      end
   end

   // memory port control
   always_comb begin
      mem_we    = 4'd0;
      mem_waddr = clr_idx_ff;
      mem_raddr = cmd.fetch_en ? pc_ff[WAW+1:2] : ea[WAW+1:2];
      for (int l = 0; l < 4; l++) mem_wdata[l] = 8'd0;
      if (cmd.clear_en) begin
         mem_we = 4'hF;
      end else if (cmd.load_en) begin
         mem_waddr = ld_addr33[WAW+1:2];
         for (int l = 0; l < 4; l++) mem_wdata[l] = req_ff.load_byte;
         if (ld_addr33 < MEM_END) mem_we = 4'd1 << req_ff.load_addr[1:0];
      end else if (cmd.exec_en && st_store_mem) begin
         mem_waddr = ea[WAW+1:2];
         for (int l = 0; l < 4; l++) begin
            mem_wdata[l] = st_byte ? b_data_ff[7:0] : b_data_ff[8*l +: 8];
         end
         mem_we = st_byte ? (4'd1 << ea[1:0]) : 4'hF;
      end
   end

   // byte-lane banks
   for (genvar g = 0; g < 4; g++) begin : g_bank
      always_ff @(posedge clock) begin
         if (mem_we[g]) mem_bank[g][mem_waddr] <= mem_wdata[g];
         mem_rdata_ff[g] <= mem_bank[g][mem_raddr];
      end
   end

endmodule

// ===== rtl/rv32e_subset_core_step_unit.sv =====
// Top level: RV32E-subset core stepping one instruction or memory byte write per word.
`timescale 1ns / 1ps
// Usage:
//  req channel: req_word.cmd = 0 writes load_byte at load_addr into memory
//  (addresses past memory are ignored); cmd = 1 executes the instruction at PC.
//  rsp channel: exactly one result word per request word: status, next PC
//  and an optional frame-buffer pixel write with byte enables.
//  The sequence is fetch, register read, execute, optional data read, then the
//  result register; a byte write goes from fetch to a memory write, and a
//  fetch fault straight to the result. One word is in work at a time and the
//  controller returns to idle after loading a result; the next request word
//  can be accepted while an earlier result still waits.
//  Reset: the memory is swept to zero one 4-byte row per cycle while
//  req_stall stays high; PC and registers clear.
//  A stalled rsp holds its word; the unit finishes its work and waits with
//  the next result until the output register is taken.
module rv32e_subset_core_step_unit #(
   parameter int unsigned MEM_BYTES = rvstep_pkg::MEM_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  rvstep_pkg::req_word_type req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rvstep_pkg::rsp_word_type rsp_word
);
   import rvstep_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   state_type    state;

   rvstep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd),
      .state     (state)
   );

   rvstep_dpath #(.MEM_BYTES(MEM_BYTES)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   // one word in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word accepted while busy");

   // a pixel write is only reported with status ok
   a_pix_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.pixel_write) |-> (rsp_word.status == ST_OK))
      else $error("pixel write with bad status");

   // no byte enables without a pixel write
   a_pix_be: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.pixel_write) |-> (rsp_word.pixel_byte_enable == 4'd0))
      else $error("byte enables without pixel write");

   // results only leave after the clear sweep has finished
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      (state == S_CLEAR) |-> !rsp_valid)
      else $error("result during memory clear");

endmodule

// ===== tb/step_checker.sv =====
// Checker: watches both channels of the step unit, predicts each result word and compares.
`timescale 1ns / 1ps
module step_checker
   import rvstep_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   output int           fail_count,
   output int           pending
);

   localparam int unsigned SHADOW_BYTES = MEM_BYTES_DEF;
   localparam logic [31:0] FB_SPAN      = 32'h0004_0000;

   // shadow copy of the core state
   logic [31:0] core_pc;
   logic [31:0] core_regs [16];
   logic [7:0]  core_mem [SHADOW_BYTES];

   rsp_word_type expected_words [$];

   function automatic logic [31:0] sext12(input logic [11:0] v);
      return {{20{v[11]}}, v};
   endfunction

   function automatic logic word_fits(input logic [31:0] a);
      return (a[1:0] == 2'b00) && ({32'b0, a} + 64'd4 <= 64'(SHADOW_BYTES));
   endfunction

   function automatic logic byte_fits(input logic [31:0] a);
      return {32'b0, a} < 64'(SHADOW_BYTES);
   endfunction

   function automatic logic [31:0] mem_word(input logic [31:0] a);
      return {core_mem[a[15:0] + 16'd3], core_mem[a[15:0] + 16'd2],
              core_mem[a[15:0] + 16'd1], core_mem[a[15:0]]};
   endfunction

   function automatic void write_reg(input logic [4:0] r, input logic [31:0] v);
      if (r != 5'd0 && r < 5'd16) core_regs[r[3:0]] = v;
   endfunction

   // execute one request word on the shadow state, return its result word
   function automatic rsp_word_type execute_word(input req_word_type w);
      rsp_word_type r;
      logic [31:0]  insn, a1, a2, npc, addr, off, immi, imms;
      logic [6:0]   op, f7;
      logic [4:0]   rd, rs1, rs2;
      logic [2:0]   f3;
      logic [1:0]   lane;
      r = '0;
      r.status = ST_OK;
      if (w.cmd == CMD_LOAD) begin
         if (byte_fits({16'b0, w.load_addr})) core_mem[w.load_addr] = w.load_byte;
      end else if (!word_fits(core_pc)) begin
         r.status = ST_MEMFAULT;
      end else begin
         insn = mem_word(core_pc);
         op   = insn[6:0];
         rd   = insn[11:7];
         f3   = insn[14:12];
         rs1  = insn[19:15];
         rs2  = insn[24:20];
         f7   = insn[31:25];
         immi = sext12(insn[31:20]);
         imms = sext12({insn[31:25], insn[11:7]});
         a1   = core_regs[rs1[3:0]];
         a2   = core_regs[rs2[3:0]];
         npc  = core_pc + 32'd4;
         r.status = ST_ILLEGAL;
         if (op == OP_IMM && f3 == F3_ADD) begin
            if (rd < 16 && rs1 < 16) begin
               write_reg(rd, a1 + immi);
               r.status = ST_OK;
            end
         end else if (op == OP_JALR && f3 == F3_ADD) begin
            if (rd < 16 && rs1 < 16) begin
               write_reg(rd, npc);
               npc = (a1 + immi) & ~32'd1;
               r.status = ST_OK;
            end
         end else if (op == OP_REG && f3 == F3_ADD && f7 == 7'd0) begin
            if (rd < 16 && rs1 < 16 && rs2 < 16) begin
               write_reg(rd, a1 + a2);
               r.status = ST_OK;
            end
         end else if (op == OP_LUI) begin
            if (rd < 16) begin
               write_reg(rd, insn & LUI_MASK);
               r.status = ST_OK;
            end
         end else if (op == OP_LOAD && (f3 == F3_W || f3 == F3_BU)) begin
            if (rd < 16 && rs1 < 16) begin
               addr = a1 + immi;
               if (f3 == F3_W) begin
                  if (word_fits(addr)) begin
                     write_reg(rd, mem_word(addr));
                     r.status = ST_OK;
                  end else r.status = ST_MEMFAULT;
               end else begin
                  if (byte_fits(addr)) begin
                     write_reg(rd, {24'b0, core_mem[addr[15:0]]});
                     r.status = ST_OK;
                  end else r.status = ST_MEMFAULT;
               end
            end
         end else if (op == OP_STORE && (f3 == F3_W || f3 == F3_B)) begin
            if (rs1 < 16 && rs2 < 16) begin
               addr = a1 + imms;
               if (addr >= FB_BASE && addr - FB_BASE < FB_SPAN) begin
                  // frame buffer: emit a pixel write instead of storing
                  off  = addr - FB_BASE;
                  lane = off[1:0];
                  r.status = ST_OK;
                  if (f3 == F3_B) begin
                     r.pixel_write       = 1'b1;
                     r.pixel_num         = off[17:2];
                     r.pixel_data        = {24'b0, a2[7:0]} << (lane * 8);
                     r.pixel_byte_enable = 4'd1 << lane;
                  end else if (lane == 2'd0) begin
                     r.pixel_write       = 1'b1;
                     r.pixel_num         = off[17:2];
                     r.pixel_data        = a2;
                     r.pixel_byte_enable = 4'hF;
                  end
               end else if (f3 == F3_W) begin
                  if (word_fits(addr)) begin
                     core_mem[addr[15:0]]         = a2[7:0];
                     core_mem[addr[15:0] + 16'd1] = a2[15:8];
                     core_mem[addr[15:0] + 16'd2] = a2[23:16];
                     core_mem[addr[15:0] + 16'd3] = a2[31:24];
                     r.status = ST_OK;
                  end else r.status = ST_MEMFAULT;
               end else begin
                  if (byte_fits(addr)) begin
                     core_mem[addr[15:0]] = a2[7:0];
                     r.status = ST_OK;
                  end else r.status = ST_MEMFAULT;
               end
            end
         end else if (insn == EBREAK_WORD) begin
            r.status = (core_regs[REG_A0] == 32'd0) ? ST_GOOD : ST_BAD;
         end
         if (r.status == ST_OK) core_pc = npc;
      end
      r.next_pc = core_pc;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // channel monitor: pop and compare results, predict on accepted requests
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         core_pc = '0;
         for (int i = 0; i < 16; i++) core_regs[i] = '0;
         for (int i = 0; i < SHADOW_BYTES; i++) core_mem[i] = '0;
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected result word %h", $time, rsp_word);
               fail_count++;
            end else begin
               exp_w = expected_words.pop_front();
               check_field("status", 32'(exp_w.status), 32'(rsp_word.status));
               check_field("next_pc", exp_w.next_pc, rsp_word.next_pc);
               check_field("pixel_write", 32'(exp_w.pixel_write), 32'(rsp_word.pixel_write));
               check_field("pixel_num", 32'(exp_w.pixel_num), 32'(rsp_word.pixel_num));
               check_field("pixel_data", exp_w.pixel_data, rsp_word.pixel_data);
               check_field("pixel_byte_enable", 32'(exp_w.pixel_byte_enable),
                           32'(rsp_word.pixel_byte_enable));
            end
         end
         if (req_valid && !req_stall) expected_words.push_back(execute_word(req_word));
      end
      pending = expected_words.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives programs into the step unit and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
   import rvstep_pkg::*;

   localparam int LIMIT     = 600000;
   localparam int HOLD_LEN  = 300;
   localparam int NUM_ITEMS = 1500;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int          fail_count, pending;
   int          send_idle = 0, recv_idle = 0;
   int          hold_asks = 0, hold_taken = 0;
   int          words_sent = 0, steps_sent = 0, cycles = 0;
   logic [31:0] seen_pc = '0;

   rv32e_subset_core_step_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   step_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // last PC reported by the unit
   always @(posedge clock)
      if (rsp_valid && !rsp_stall) seen_pc <= rsp_word.next_pc;

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            rsp_stall <= 1'b1;
            repeat (HOLD_LEN) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   // instruction encoders
   function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [4:0] rd,
                                         input logic [2:0] f3, input logic [4:0] rs1,
                                         input logic [11:0] imm);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                         input logic [4:0] rs2, input logic [11:0] imm);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
   endfunction

   function automatic logic [31:0] enc_add(input logic [4:0] rd, input logic [4:0] rs1,
                                           input logic [4:0] rs2);
      return {7'd0, rs2, rs1, F3_ADD, rd, OP_REG};
   endfunction

   function automatic logic [31:0] enc_lui(input logic [4:0] rd, input logic [19:0] upper);
      return {upper, rd, OP_LUI};
   endfunction

   // called at a rising edge; returns at the edge where the word was taken
   task automatic send_word(input logic c, input logic [15:0] a, input logic [7:0] b);
      logic stalled;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_word  <= '{cmd: c, load_addr: a, load_byte: b};
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      words_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // place an instruction at the current PC, step it, wait for its result
   task automatic run_insn(input logic [31:0] insn);
      for (int i = 0; i < 4; i++)
         send_word(CMD_LOAD, seen_pc[15:0] + 16'(i), insn[8*i +: 8]);
      send_word(CMD_STEP, 16'($urandom), 8'($urandom));
      steps_sent++;
      drain();
   endtask

   function automatic logic [4:0] any_reg;
      return 5'($urandom_range(15));
   endfunction

   // one random instruction or short sequence
   task automatic random_insn;
      int          pick;
      logic [4:0]  base;
      logic [11:0] imm;
      pick = $urandom_range(99);
      imm  = 12'($urandom_range(511) * 4);
      if (pick < 14) begin
         run_insn(enc_i(OP_IMM, any_reg(), F3_ADD, any_reg(), 12'($urandom)));
      end else if (pick < 23) begin
         run_insn(enc_add(any_reg(), any_reg(), any_reg()));
      end else if (pick < 30) begin
         run_insn(enc_lui(any_reg(), 20'($urandom)));
      end else if (pick < 42) begin
         // loads: mostly from low memory, sometimes from a random register
         base = ($urandom_range(3) == 0) ? any_reg() : 5'd0;
         if ($urandom_range(1)) run_insn(enc_i(OP_LOAD, any_reg(), F3_W, base,
                                               imm | 12'($urandom_range(7) == 0)));
         else run_insn(enc_i(OP_LOAD, any_reg(), F3_BU, base, 12'($urandom_range(2047))));
      end else if (pick < 62) begin
         // frame buffer: point a register into the window, then store through it
         base = 5'($urandom_range(1, 15));
         run_insn(enc_lui(base, 20'h20000 + 20'($urandom_range(63))));
         run_insn(enc_s($urandom_range(1) ? F3_W : F3_B, base, any_reg(), 12'($urandom)));
      end else if (pick < 72) begin
         if ($urandom_range(1)) run_insn(enc_s(F3_W, 5'd0, any_reg(), imm));
         else run_insn(enc_s(F3_B, 5'd0, any_reg(), 12'($urandom_range(2047))));
      end else if (pick < 80) begin
         run_insn(enc_i(OP_JALR, any_reg(), F3_ADD, 5'd0, imm | 12'($urandom_range(1))));
      end else if (pick < 86) begin
         // illegal: random word or a reserved register number
         if ($urandom_range(1)) run_insn($urandom);
         else run_insn(enc_i(OP_IMM, 5'($urandom_range(16, 31)), F3_ADD, any_reg(), 12'd1));
      end else if (pick < 91) begin
         if ($urandom_range(1)) run_insn(enc_i(OP_IMM, 5'(REG_A0), F3_ADD, 5'd0, 12'd0));
         run_insn(EBREAK_WORD);
      end else begin
         send_word(CMD_LOAD, 16'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every operation, window and fault corners
      send_word(CMD_LOAD, 16'hFFFF, 8'hA5);
      run_insn(enc_i(OP_IMM, 5'd1, F3_ADD, 5'd0, 12'hFFF));
      run_insn(enc_i(OP_IMM, 5'd0, F3_ADD, 5'd1, 12'h7FF));
      run_insn(enc_add(5'd2, 5'd1, 5'd1));
      run_insn(enc_lui(5'd3, 20'h00010));
      run_insn(enc_i(OP_IMM, 5'd3, F3_ADD, 5'd3, 12'hFFC));
      run_insn(enc_s(F3_W, 5'd3, 5'd2, 12'd0));
      run_insn(enc_i(OP_LOAD, 5'd4, F3_W, 5'd3, 12'd0));
      run_insn(enc_i(OP_LOAD, 5'd5, F3_BU, 5'd3, 12'd3));
      run_insn(enc_i(OP_LOAD, 5'd4, F3_W, 5'd3, 12'd4));
      run_insn(enc_i(OP_LOAD, 5'd4, F3_W, 5'd3, 12'd2));
      run_insn(enc_s(F3_B, 5'd3, 5'd1, 12'd4));
      run_insn(enc_lui(5'd6, 20'h20000));
      run_insn(enc_s(F3_W, 5'd6, 5'd2, 12'd0));
      run_insn(enc_s(F3_B, 5'd6, 5'd2, 12'd3));
      run_insn(enc_s(F3_W, 5'd6, 5'd1, 12'd2));
      run_insn(enc_s(F3_W, 5'd6, 5'd1, 12'hFFC));
      run_insn(enc_lui(5'd7, 20'h2003F));
      run_insn(enc_s(F3_B, 5'd7, 5'd1, 12'h7FF));
      run_insn(enc_i(OP_IMM, 5'd16, F3_ADD, 5'd1, 12'd1));
      run_insn(32'd0);
      run_insn(EBREAK_WORD);
      run_insn(enc_i(OP_IMM, 5'(REG_A0), F3_ADD, 5'd0, 12'd1));
      run_insn(EBREAK_WORD);
      run_insn(enc_i(OP_JALR, 5'd15, F3_ADD, 5'd0, 12'h100));

      // random phases: sender idles lightly, then receiver lightly, then none
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 10 : (phase == 1) ? 56 : 0;
         recv_idle = (phase == 0) ? 56 : (phase == 1) ? 10 : 0;
         if (phase == 2) begin
            // long receiver hold-off while byte writes keep coming
            hold_asks++;
            for (int i = 0; i < 40; i++) send_word(CMD_LOAD, 16'($urandom), 8'($urandom));
            drain();
         end
         while (words_sent < NUM_ITEMS * (phase + 1) / 3) random_insn();
      end

      // finally jump to a misaligned PC: every later fetch faults
      run_insn(enc_i(OP_JALR, 5'd0, F3_ADD, 5'd0, 12'h102));
      for (int i = 0; i < 3; i++) send_word(CMD_STEP, 16'($urandom), 8'($urandom));
      drain();
      repeat (20) @(posedge clock);

      $display("Covered %0d words, %0d of them instruction steps, over three idle mixes",
               words_sent, steps_sent);
      $display("plus a long result hold-off and a closing run of fetch faults");
      if (fail_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
